/* rtl/single_linkage_union_find_unit_assert.svh */
// Assertion macros for the checker file of the union-find block.
`ifndef SINGLE_LINKAGE_UNION_FIND_UNIT_ASSERT_SVH
`define SINGLE_LINKAGE_UNION_FIND_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLUFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("union-find check failed");

// Next-cycle implication, checked outside reset.
`define SLUFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("union-find check failed");

`endif

/* rtl/slufu_pkg.sv */
package slufu_pkg;

  // Field widths
  localparam int POINT_W    = 8;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam int MAX_POINTS_DEF = 256;
  localparam int TABLE_CAP      = 256;  // points are 8 bits wide

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CLUSTERS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] POINTS_RESET = 9'd256;
  localparam logic [CFG_DATA_W-1:0] TARGET_RESET = 9'd1;

  // Program steps
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_A_FETCH = 3'd1,
    ST_A_EVAL  = 3'd2,
    ST_B_SETUP = 3'd3,
    ST_B_FETCH = 3'd4,
    ST_B_EVAL  = 3'd5,
    ST_UNITE   = 3'd6,
    ST_EMIT    = 3'd7
  } step_t;

  // Datapath actions
  typedef enum logic [2:0] {
    ACT_ACCEPT,
    ACT_WAIT,
    ACT_EVAL_A,
    ACT_SETUP_B,
    ACT_EVAL_B,
    ACT_UNITE,
    ACT_EMIT
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    CND_NONE,
    CND_NO_INPUT,
    CND_NOT_ROOT,
    CND_SKIP_B,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Control store: jump to target when the condition holds, else advance
  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:    w = '{act: ACT_ACCEPT,  cond: CND_NO_INPUT, target: ST_IDLE};
      ST_A_FETCH: w = '{act: ACT_WAIT,    cond: CND_NONE,     target: ST_IDLE};
      ST_A_EVAL:  w = '{act: ACT_EVAL_A,  cond: CND_NOT_ROOT, target: ST_A_FETCH};
      ST_B_SETUP: w = '{act: ACT_SETUP_B, cond: CND_SKIP_B,   target: ST_EMIT};
      ST_B_FETCH: w = '{act: ACT_WAIT,    cond: CND_NONE,     target: ST_IDLE};
      ST_B_EVAL:  w = '{act: ACT_EVAL_B,  cond: CND_NOT_ROOT, target: ST_B_FETCH};
      ST_UNITE:   w = '{act: ACT_UNITE,   cond: CND_NONE,     target: ST_IDLE};
      ST_EMIT:    w = '{act: ACT_EMIT,    cond: CND_OUT_BUSY, target: ST_EMIT};
      default:    w = '{act: ACT_WAIT,    cond: CND_NONE,     target: ST_IDLE};
    endcase
    return w;
  endfunction

  // Clamp points_in_use to 1 .. max_pts
  function automatic logic [CFG_DATA_W-1:0] eff_points(logic [CFG_DATA_W-1:0] v,
                                                       int max_pts);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (int'(v) > max_pts) begin
      r = CFG_DATA_W'(max_pts);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Zero target counts as one
  function automatic logic [CFG_DATA_W-1:0] eff_target(logic [CFG_DATA_W-1:0] v);
    return (v == '0) ? CFG_DATA_W'(1) : v;
  endfunction

endpackage

/* rtl/single_linkage_union_find_unit.sv */
// Union-find engine for single-linkage clustering.
// Input channel (in_valid/in_ready): one transaction is a merge edge
// (in_req_type 0, endpoints in_point_a/in_point_b) or a query of in_point_a
// (in_req_type 1). Each input transaction yields exactly one result
// transaction on out_valid/out_ready: the root of point_a, the merged and
// done_res flags and the remaining cluster count.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes
// points_in_use and resets every point to a singleton at once; index 1 writes
// target_clusters. Write only while no item is in flight.
// A sequencer walks parent chains in a table memory with registered
// read. A query, or a merge edge that is ignored, walks only the chain
// above point_a before its result is registered; a merge that walks both
// chains also walks the chain above point_b and unites the two roots. A
// new item is taken in the cycle after its predecessor's result is
// registered, so the block takes no new item while one is in flight.
// Reset: all points are singletons, points_in_use 256, target_clusters 1.
// A stalled receiver holds the result register; the block waits in its last
// step until the result register is free and takes no new item meanwhile.
module single_linkage_union_find_unit #(
  parameter int MAX_POINTS = slufu_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [slufu_pkg::POINT_W-1:0]    in_point_a,
  input  logic [slufu_pkg::POINT_W-1:0]    in_point_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [slufu_pkg::POINT_W-1:0]    out_representative,
  output logic                             out_merged,
  output logic [slufu_pkg::COUNT_W-1:0]    out_cluster_count,
  output logic                             out_done_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slufu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slufu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TD = (MAX_POINTS < slufu_pkg::TABLE_CAP) ? MAX_POINTS
                                                          : slufu_pkg::TABLE_CAP;
  localparam int IW = $clog2(TD);
  localparam int PW = slufu_pkg::POINT_W;
  localparam int CW = slufu_pkg::COUNT_W;
  localparam int DW = slufu_pkg::CFG_DATA_W;

  // Sequencer
  slufu_pkg::step_t  step_r, step_nxt;
  slufu_pkg::uword_t uw;
  logic              jump;

  // Datapath registers
  logic [PW-1:0] x_r, x_nxt;
  logic [PW-1:0] b_r, b_nxt;
  logic [PW-1:0] ra_r, ra_nxt;
  logic [PW-1:0] rb_r, rb_nxt;
  logic          skip_r, skip_nxt;
  logic          done_r, done_nxt;
  logic          merged_r, merged_nxt;
  logic [CW-1:0] set_count_r, set_count_nxt;
  logic [DW-1:0] points_r, points_nxt;
  logic [DW-1:0] target_r, target_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_rep_r, out_rep_nxt;
  logic          out_merged_r, out_merged_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          out_done_r, out_done_nxt;

  // Parent table
  logic [IW-1:0] parent_mem [TD];
  logic [TD-1:0] vld_r;
  logic [IW-1:0] rd_data_r;
  logic          rd_vld_r;
  logic          wr_en;
  logic          tbl_clr;

  logic [DW-1:0] eff_n;
  logic [DW-1:0] eff_t;
  logic [PW-1:0] p_ext;
  logic          x_out;
  logic          root_hit;
  logic          out_free;
  logic          in_done;

  assign uw        = slufu_pkg::ucode(step_r);
  assign in_ready  = (uw.act == slufu_pkg::ACT_ACCEPT);
  assign cfg_ready = 1'b1;

  assign eff_n = slufu_pkg::eff_points(points_r, MAX_POINTS);
  assign eff_t = slufu_pkg::eff_target(target_r);

  // Parent of the current point; entries never written point to themselves
  assign p_ext    = rd_vld_r ? PW'(rd_data_r) : x_r;
  assign x_out    = ({1'b0, x_r} >= eff_n);
  assign root_hit = x_out || (p_ext == x_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_done  = !in_req_type && (set_count_r <= eff_t);

  // Next state and datapath actions
  always_comb begin
    x_nxt          = x_r;
    b_nxt          = b_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    skip_nxt       = skip_r;
    done_nxt       = done_r;
    merged_nxt     = merged_r;
    set_count_nxt  = set_count_r;
    points_nxt     = points_r;
    target_nxt     = target_r;
    out_valid_nxt  = out_valid_r;
    out_rep_nxt    = out_rep_r;
    out_merged_nxt = out_merged_r;
    out_count_nxt  = out_count_r;
    out_done_nxt   = out_done_r;
    wr_en          = 1'b0;
    tbl_clr        = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (uw.act)
      slufu_pkg::ACT_ACCEPT: begin
        if (in_valid) begin
          x_nxt      = in_point_a;
          b_nxt      = in_point_b;
          done_nxt   = in_done;
          merged_nxt = 1'b0;
          skip_nxt   = in_req_type || in_done || ({1'b0, in_point_a} >= eff_n) ||
                       ({1'b0, in_point_b} >= eff_n);
        end
      end
      slufu_pkg::ACT_WAIT: begin
      end
      slufu_pkg::ACT_EVAL_A: begin
        if (root_hit) begin
          ra_nxt = x_r;
        end else begin
          x_nxt = p_ext;
        end
      end
      slufu_pkg::ACT_SETUP_B: begin
        x_nxt = b_r;
      end
      slufu_pkg::ACT_EVAL_B: begin
        if (root_hit) begin
          rb_nxt = x_r;
        end else begin
          x_nxt = p_ext;
        end
      end
      slufu_pkg::ACT_UNITE: begin
        // Attach b's root under a's root
        if (ra_r != rb_r) begin
          wr_en         = 1'b1;
          set_count_nxt = set_count_r - CW'(1);
          merged_nxt    = 1'b1;
        end
      end
      slufu_pkg::ACT_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rep_nxt    = ra_r;
          out_merged_nxt = merged_r;
          out_count_nxt  = set_count_r;
          out_done_nxt   = done_r;
        end
      end
      default: begin
      end
    endcase

    unique case (uw.cond)
      slufu_pkg::CND_NONE:     jump = 1'b0;
      slufu_pkg::CND_NO_INPUT: jump = !in_valid;
      slufu_pkg::CND_NOT_ROOT: jump = !root_hit;
      slufu_pkg::CND_SKIP_B:   jump = skip_r;
      slufu_pkg::CND_OUT_BUSY: jump = !out_free;
      default:                 jump = 1'b0;
    endcase

    // Last step wraps back to idle
    step_nxt = jump ? uw.target : slufu_pkg::step_t'(step_r + 3'd1);

    // Configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        slufu_pkg::CFG_POINTS_IN_USE: begin
          points_nxt    = cfg_data;
          set_count_nxt = CW'(slufu_pkg::eff_points(cfg_data, MAX_POINTS));
          tbl_clr       = 1'b1;
        end
        slufu_pkg::CFG_TARGET_CLUSTERS: begin
          target_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= slufu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      points_r    <= slufu_pkg::POINTS_RESET;
      target_r    <= slufu_pkg::TARGET_RESET;
      set_count_r <= CW'(slufu_pkg::eff_points(slufu_pkg::POINTS_RESET, MAX_POINTS));
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      points_r    <= points_nxt;
      target_r    <= target_nxt;
      set_count_r <= set_count_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    b_r          <= b_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    skip_r       <= skip_nxt;
    done_r       <= done_nxt;
    merged_r     <= merged_nxt;
    out_rep_r    <= out_rep_nxt;
    out_merged_r <= out_merged_nxt;
    out_count_r  <= out_count_nxt;
    out_done_r   <= out_done_nxt;
  end

  // Parent table memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_mem[rb_r[IW-1:0]] <= ra_r[IW-1:0];
    end
    rd_data_r <= parent_mem[x_r[IW-1:0]];
  end

  // Entry valid bits; clear all on reset or a points_in_use write
  always_ff @(posedge clk) begin
    if (!rst_n || tbl_clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[rb_r[IW-1:0]] <= 1'b1;
      end
      rd_vld_r <= vld_r[x_r[IW-1:0]];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_representative = out_rep_r;
  assign out_merged         = out_merged_r;
  assign out_cluster_count  = out_count_r;
  assign out_done_res       = out_done_r;

endmodule

/* rtl/slufu_checker.sv */
`include "single_linkage_union_find_unit_assert.svh"

module slufu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [slufu_pkg::POINT_W-1:0]    out_representative,
  input logic                             out_merged,
  input logic [slufu_pkg::COUNT_W-1:0]    out_cluster_count,
  input logic                             out_done_res
);

  // Hold a stalled result transaction
  `SLUFU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_representative) && $stable(out_merged) && $stable(out_cluster_count) && $stable(out_done_res))

  // An edge past the target never reports a merge
  `SLUFU_ASSERT_NOW(a_done_excl, clk, rst_n, out_valid, !(out_merged && out_done_res))

  // One item at a time: no new transaction right after an accept
  `SLUFU_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind single_linkage_union_find_unit slufu_checker u_slufu_checker (.*);

/* tb/sv/uf_tb_pkg.sv */
`timescale 1ns / 1ps

package uf_tb_pkg;

  import slufu_pkg::*;

  // Request kinds on the input channel
  localparam logic REQ_MERGE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // One result transaction
  typedef struct packed {
    logic [POINT_W-1:0] representative;
    logic               merged;
    logic [COUNT_W-1:0] cluster_count;
    logic               done_res;
  } uf_result_t;

endpackage

/* tb/sv/union_find_checker.sv */
`timescale 1ns / 1ps

module union_find_checker
  import slufu_pkg::*;
  import uf_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [POINT_W-1:0]    in_point_a,
  input  logic [POINT_W-1:0]    in_point_b,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [POINT_W-1:0]    out_representative,
  input  logic                  out_merged,
  input  logic [COUNT_W-1:0]    out_cluster_count,
  input  logic                  out_done_res,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    merges_seen,
  output int                    dones_seen
);

  // Shadow copy of the block state
  logic [POINT_W-1:0]    parent_tbl [TABLE_CAP];
  logic [COUNT_W-1:0]    cluster_total;
  logic [CFG_DATA_W-1:0] points_reg;
  logic [CFG_DATA_W-1:0] target_reg;

  uf_result_t expected_results [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    merges_seen     = 0;
    dones_seen      = 0;
  end

  // Clamp the point count to 1 .. table size
  function automatic logic [COUNT_W-1:0] live_points();
    logic [COUNT_W-1:0] n;
    n = points_reg;
    if (n == '0) n = COUNT_W'(1);
    if (n > TABLE_CAP) n = COUNT_W'(TABLE_CAP);
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] live_target();
    return (target_reg == '0) ? COUNT_W'(1) : target_reg;
  endfunction

  // Make every point a singleton again
  function automatic void clear_forest();
    for (int i = 0; i < TABLE_CAP; i++) parent_tbl[i] = POINT_W'(i);
    cluster_total = live_points();
  endfunction

  // Follow parent links up to the root; points out of use are their own root
  function automatic logic [POINT_W-1:0] find_root(logic [POINT_W-1:0] x);
    logic [POINT_W-1:0] node;
    int                 steps;
    node  = x;
    steps = 0;
    if (x >= live_points()) return x;
    while (steps < TABLE_CAP && parent_tbl[node] != node) begin
      node = parent_tbl[node];
      steps++;
    end
    return node;
  endfunction

  // Apply one request to the shadow forest and build its result
  function automatic uf_result_t cluster_step(logic kind, logic [POINT_W-1:0] a,
                                             logic [POINT_W-1:0] b);
    uf_result_t         r;
    logic [POINT_W-1:0] ra;
    logic [POINT_W-1:0] rb;
    r = '0;
    if (kind == REQ_MERGE) begin
      if (cluster_total <= live_target()) begin
        r.done_res = 1'b1;
      end else if (a < live_points() && b < live_points()) begin
        ra = find_root(a);
        rb = find_root(b);
        if (ra != rb) begin
          parent_tbl[rb] = ra;
          cluster_total  = cluster_total - 1'b1;
          r.merged       = 1'b1;
        end
      end
    end
    r.representative = find_root(a);
    r.cluster_count  = cluster_total;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result();
    uf_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing outstanding (rep %0d count %0d)",
                                out_representative, out_cluster_count));
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (out_representative !== want.representative)
        report_mismatch($sformatf("representative %0d, expected %0d",
                                  out_representative, want.representative));
      if (out_merged !== want.merged)
        report_mismatch($sformatf("merged %0b, expected %0b", out_merged, want.merged));
      if (out_cluster_count !== want.cluster_count)
        report_mismatch($sformatf("cluster_count %0d, expected %0d",
                                  out_cluster_count, want.cluster_count));
      if (out_done_res !== want.done_res)
        report_mismatch($sformatf("done_res %0b, expected %0b",
                                  out_done_res, want.done_res));
      if (want.merged) merges_seen++;
      if (want.done_res) dones_seen++;
    end
  endtask

  // Watch all three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      points_reg = POINTS_RESET;
      target_reg = TARGET_RESET;
      clear_forest();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_POINTS_IN_USE) begin
          points_reg = cfg_data;
          clear_forest();
        end else if (cfg_index == CFG_TARGET_CLUSTERS) begin
          target_reg = cfg_data;
        end
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(),
                                cluster_step(in_req_type, in_point_a, in_point_b));
    end
    pending = expected_results.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

  import slufu_pkg::*;
  import uf_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PAUSE     = 16;
  localparam int WATCHDOG_LIMIT = 6000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [POINT_W-1:0]    in_point_a;
  logic [POINT_W-1:0]    in_point_b;
  logic                  out_valid;
  logic                  out_ready;
  logic [POINT_W-1:0]    out_representative;
  logic                  out_merged;
  logic [COUNT_W-1:0]    out_cluster_count;
  logic                  out_done_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int results_checked;
  int merges_seen;
  int dones_seen;

  int items_sent;
  int reg_writes;
  int chains_built;
  int burst_left;
  int idle_cycles;
  int long_holds;
  bit valid_held;
  bit stall_request;

  single_linkage_union_find_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_point_a        (in_point_a),
    .in_point_b        (in_point_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_representative(out_representative),
    .out_merged        (out_merged),
    .out_cluster_count (out_cluster_count),
    .out_done_res      (out_done_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  union_find_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_point_a        (in_point_a),
    .in_point_b        (in_point_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_representative(out_representative),
    .out_merged        (out_merged),
    .out_cluster_count (out_cluster_count),
    .out_done_res      (out_done_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (mismatches),
    .pending           (pending),
    .results_checked   (results_checked),
    .merges_seen       (merges_seen),
    .dones_seen        (dones_seen)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: end the run after too many cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request) begin
        out_ready <= 1'b0;
        stall_request = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_holds++;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ((cyc / 8) % 2 == 0);
        end
      endcase
      cyc++;
      @(posedge clk);
    end
  end

  // Offer one request and hold it until accepted; idle between bursts
  task automatic send_item(input logic kind, input logic [POINT_W-1:0] a,
                           input logic [POINT_W-1:0] b);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_point_a  <= a;
    in_point_b  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    valid_held = 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  // Drop valid and wait until every result has been taken
  task automatic wait_idle();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // Mixed traffic over a random configuration
  task automatic mixed_phase();
    int pts;
    int eff;
    int tgt;
    int len;
    int pick;
    logic [POINT_W-1:0] a;
    logic [POINT_W-1:0] b;
    case ($urandom_range(0, 9))
      0:       pts = 0;
      1:       pts = 1;
      2:       pts = 2;
      3, 4, 5: pts = $urandom_range(3, 16);
      6:       pts = $urandom_range(17, 64);
      7:       pts = 256;
      8:       pts = $urandom_range(257, 511);
      default: pts = $urandom_range(65, 255);
    endcase
    eff = (pts == 0) ? 1 : (pts > 256) ? 256 : pts;
    case ($urandom_range(0, 9))
      0:          tgt = 0;
      1:          tgt = 1;
      7:          tgt = eff;
      8:          tgt = $urandom_range(eff, 511);
      9:          tgt = ($urandom_range(0, 1) == 0) ? 256 : 511;
      default:    tgt = $urandom_range(1, (eff > 2) ? eff / 2 : 1);
    endcase
    write_reg(CFG_POINTS_IN_USE, CFG_DATA_W'(pts));
    write_reg(CFG_TARGET_CLUSTERS, CFG_DATA_W'(tgt));
    len = (eff > 32) ? $urandom_range(120, 260) : $urandom_range(25, 70);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      a    = POINT_W'($urandom_range(0, eff - 1));
      b    = POINT_W'($urandom_range(0, eff - 1));
      if (pick < 55) begin
        send_item(REQ_MERGE, a, b);
      end else if (pick < 80) begin
        send_item(REQ_QUERY, a, POINT_W'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        // endpoints anywhere, often out of use
        send_item(REQ_MERGE, POINT_W'($urandom_range(0, 255)),
                  POINT_W'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        send_item(REQ_MERGE, a, a);
      end else begin
        send_item(REQ_QUERY, POINT_W'($urandom_range(0, 255)),
                  POINT_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Build one deep chain, then walk it from the bottom
  task automatic chain_phase();
    int pts;
    pts = $urandom_range(32, 256);
    write_reg(CFG_POINTS_IN_USE, CFG_DATA_W'(pts));
    write_reg(CFG_TARGET_CLUSTERS, CFG_DATA_W'($urandom_range(0, 1)));
    for (int k = 0; k < pts - 1; k++) begin
      send_item(REQ_MERGE, POINT_W'(k + 1), POINT_W'(k));
      if ($urandom_range(0, 9) == 0)
        send_item(REQ_QUERY, POINT_W'($urandom_range(0, k)),
                  POINT_W'($urandom_range(0, 255)));
    end
    repeat (4) send_item(REQ_QUERY, POINT_W'($urandom_range(0, 3)),
                         POINT_W'($urandom_range(0, 255)));
    chains_built++;
  endtask

  // Stimulus and verdict
  initial begin
    items_sent    = 0;
    reg_writes    = 0;
    chains_built  = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    long_holds    = 0;
    valid_held    = 1'b0;
    stall_request = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_MERGE;
    in_point_a  <= '0;
    in_point_b  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_POINTS_IN_USE;
    cfg_data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 256 points, target of one cluster
    send_item(REQ_QUERY, 8'd0, 8'd0);
    send_item(REQ_QUERY, 8'd255, 8'd255);
    send_item(REQ_MERGE, 8'd1, 8'd0);
    send_item(REQ_MERGE, 8'd0, 8'd1);
    send_item(REQ_MERGE, 8'd2, 8'd1);
    send_item(REQ_MERGE, 8'd3, 8'd2);
    send_item(REQ_MERGE, 8'd255, 8'd3);
    send_item(REQ_QUERY, 8'd0, 8'd17);
    send_item(REQ_MERGE, 8'd9, 8'd9);

    // Zero points counts as one, zero target as one: edges ignored at once
    write_reg(CFG_POINTS_IN_USE, 9'd0);
    write_reg(CFG_TARGET_CLUSTERS, 9'd0);
    send_item(REQ_MERGE, 8'd0, 8'd0);
    send_item(REQ_QUERY, 8'd200, 8'd0);

    // Four points: out-of-use endpoint, merge to one set, then done
    write_reg(CFG_POINTS_IN_USE, 9'd4);
    write_reg(CFG_TARGET_CLUSTERS, 9'd1);
    send_item(REQ_MERGE, 8'd0, 8'd7);
    send_item(REQ_MERGE, 8'd0, 8'd1);
    send_item(REQ_MERGE, 8'd2, 8'd3);
    send_item(REQ_MERGE, 8'd3, 8'd0);
    send_item(REQ_MERGE, 8'd1, 8'd2);
    send_item(REQ_QUERY, 8'd3, 8'd0);

    // Oversized point count clamps to the table; target at or above count
    write_reg(CFG_POINTS_IN_USE, 9'd511);
    write_reg(CFG_TARGET_CLUSTERS, 9'd256);
    send_item(REQ_MERGE, 8'd5, 8'd6);
    send_item(REQ_QUERY, 8'd128, 8'd0);
    write_reg(CFG_POINTS_IN_USE, 9'd300);
    write_reg(CFG_TARGET_CLUSTERS, 9'd511);
    send_item(REQ_MERGE, 8'd10, 8'd20);

    // Random phases; the receiver holds off early on while requests keep coming
    stall_request = 1'b1;
    while (items_sent < RANDOM_ITEMS + 25) begin
      if (chains_built < 3 && $urandom_range(0, 5) == 0)
        chain_phase();
      else
        mixed_phase();
    end

    wait_idle();
    $display("Checked %0d results from %0d requests: %0d merges, %0d edges past target.",
             results_checked, items_sent, merges_seen, dones_seen);
    $display("%0d register writes, %0d deep chains, %0d long receiver hold-offs.",
             reg_writes, chains_built, long_holds);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
